// ----- sv/afl_pkg.sv -----
// Package for the attitude filter with LQR mixer.
// Holds register indexes, reset values, fixed-point constants and the CORDIC table.
`timescale 1ns / 1ps
package afl_pkg;
    localparam int ANGLE_FRAC_BITS_DEF = 7;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN = 24;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_ROLL = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PITCH = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_ROLL_RATE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PITCH_RATE = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_YAW_RATE = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET = 8'd7;

    localparam logic [23:0] RST_GAIN_ROLL = 24'd51400;
    localparam logic [23:0] RST_GAIN_PITCH = 24'd67367;
    localparam logic [23:0] RST_GAIN_ROLL_RATE = 24'd15433;
    localparam logic [23:0] RST_GAIN_PITCH_RATE = 24'd20327;
    localparam logic [23:0] RST_GAIN_YAW_RATE = 24'd12114;
    localparam logic [15:0] RST_BLEND_WEIGHT = 16'd64225;
    localparam logic [23:0] RST_TIME_STEP = 24'd16777;
    localparam logic [15:0] RST_BASE_OFFSET = 16'd0;

    localparam int ZW = 26;
    localparam logic signed [ZW-1:0] DEG180_Q16 = 26'sd11796480;
    localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;

    function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        case (i)
            5'd0: r = 26'sd2949120;
            5'd1: r = 26'sd1740967;
            5'd2: r = 26'sd919879;
            5'd3: r = 26'sd466945;
            5'd4: r = 26'sd234379;
            5'd5: r = 26'sd117304;
            5'd6: r = 26'sd58666;
            5'd7: r = 26'sd29335;
            5'd8: r = 26'sd14668;
            5'd9: r = 26'sd7334;
            5'd10: r = 26'sd3667;
            5'd11: r = 26'sd1833;
            5'd12: r = 26'sd917;
            5'd13: r = 26'sd458;
            5'd14: r = 26'sd229;
            5'd15: r = 26'sd115;
            5'd16: r = 26'sd57;
            5'd17: r = 26'sd29;
            5'd18: r = 26'sd14;
            5'd19: r = 26'sd7;
            5'd20: r = 26'sd4;
            5'd21: r = 26'sd2;
            5'd22: r = 26'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

    typedef struct packed {
        logic start;
        logic signed [25:0] x;
        logic signed [25:0] y;
    } cordic_req_t;

    typedef struct packed {
        logic done;
        logic signed [ZW-1:0] z;
        logic signed [27:0] mag;
    } cordic_rsp_t;
endpackage

// ----- sv/afl_if.sv -----
// Valid/ready stream interfaces for the attitude filter.
// Depends on afl_pkg for the configuration widths.
`timescale 1ns / 1ps
interface afl_in_if;
    logic valid;
    logic ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic signed [15:0] target_roll;
    logic signed [15:0] target_pitch;
    logic signed [15:0] target_roll_rate;
    logic signed [15:0] target_pitch_rate;
    logic signed [15:0] target_yaw_rate;
    logic [15:0] thrust_level;
    modport source(output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
        target_roll, target_pitch, target_roll_rate, target_pitch_rate, target_yaw_rate,
        thrust_level, input ready);
    modport sink(input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
        target_roll, target_pitch, target_roll_rate, target_pitch_rate, target_yaw_rate,
        thrust_level, output ready);
endinterface

interface afl_out_if;
    logic valid;
    logic ready;
    logic [15:0] motor_one;
    logic [15:0] motor_two;
    logic [15:0] motor_three;
    logic [15:0] motor_four;
    logic signed [15:0] roll_estimate_out;
    logic signed [15:0] pitch_estimate_out;
    modport source(output valid, motor_one, motor_two, motor_three, motor_four,
        roll_estimate_out, pitch_estimate_out, input ready);
    modport sink(input valid, motor_one, motor_two, motor_three, motor_four,
        roll_estimate_out, pitch_estimate_out, output ready);
endinterface

interface afl_cfg_if;
    logic valid;
    logic ready;
    logic [afl_pkg::CFG_IDX_W-1:0] index;
    logic [afl_pkg::CFG_DATA_W-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ----- sv/afl_cordic.sv -----
// Iterative vectoring CORDIC, one micro-rotation per cycle.
// Depends on afl_pkg for the arctangent table and request types.
`timescale 1ns / 1ps
module afl_cordic #(
    parameter int CORDIC_STEPS = afl_pkg::CORDIC_STEPS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  afl_pkg::cordic_req_t req,
    output afl_pkg::cordic_rsp_t rsp
);
    localparam int NSTEP = (CORDIC_STEPS < afl_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                              : afl_pkg::TABLE_LEN;
    localparam int XW = 28;

    logic signed [XW-1:0] x_reg, y_reg;
    logic signed [afl_pkg::ZW-1:0] z_reg;
    logic [4:0] i_reg;
    logic busy_reg, done_reg;
    logic signed [XW-1:0] dx, dy;

    assign dx = y_reg >>> i_reg;
    assign dy = x_reg >>> i_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg <= '0;
        end
        else
        begin
            if (req.start)
            begin
                i_reg <= '0;
                if (req.x == 0 && req.y == 0)
                begin
                    z_reg <= '0;
                    x_reg <= '0;
                    y_reg <= '0;
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    done_reg <= 1'b0;
                    if (req.x < 0)
                    begin
                        z_reg <= (req.y >= 0) ? afl_pkg::DEG180_Q16 : -afl_pkg::DEG180_Q16;
                        x_reg <= -XW'(req.x);
                        y_reg <= -XW'(req.y);
                    end
                    else
                    begin
                        z_reg <= '0;
                        x_reg <= XW'(req.x);
                        y_reg <= XW'(req.y);
                    end
                end
            end
            else if (busy_reg)
            begin
                if (y_reg < 0)
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - afl_pkg::atan_q16(i_reg);
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + afl_pkg::atan_q16(i_reg);
                end
                if (i_reg == 5'(NSTEP - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    done_reg <= 1'b0;
                end
                i_reg <= i_reg + 5'd1;
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.z = z_reg;
    assign rsp.mag = x_reg;

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !done_reg) else $error("cordic done while busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg || $past(req.start)) else $error("done held");
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> i_reg < 5'(NSTEP)) else $error("cordic index out of range");
endmodule

// ----- sv/attitude_filter_lqr_mixer.sv -----
// Top level of the attitude filter with LQR motor mixer.
// Depends on afl_pkg, the afl interfaces and afl_cordic.
//
// Usage: input words arrive on in_ch (valid/ready), results leave on out_ch,
// and registers are to be written on cfg_ch only while the block is idle;
// the block itself does not enforce this. Each input word yields exactly one
// output word, and a new word is accepted only once the previous one has left
// the sequencer; a zero accelerometer vector shortens a CORDIC pass. The
// processing time is set by the two passes through the shared CORDIC, by the
// single shared multiplier that computes the magnitude scaling, the gyro
// steps, the blends and the five error terms in turn, and by the mixing of the
// four motors in turn. in_ch.ready is high only while the sequencer is idle.
// At reset the estimates are zero and the registers take their documented
// defaults. When the receiver stalls the result holds in the output register;
// the next word is still accepted and processed, and waits for the register
// before it completes.
`timescale 1ns / 1ps
module attitude_filter_lqr_mixer #(
    parameter int ANGLE_FRAC_BITS = afl_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = afl_pkg::CORDIC_STEPS_DEF
) (
    input logic clk,
    input logic rst_n,
    afl_in_if.sink in_ch,
    afl_out_if.source out_ch,
    afl_cfg_if.sink cfg_ch
);
    localparam int LIM = 180 << ANGLE_FRAC_BITS;
    localparam int GSH = 28 - ANGLE_FRAC_BITS;
    localparam int MSH = 12 + ANGLE_FRAC_BITS;
    localparam int USH = 16 - ANGLE_FRAC_BITS;
    localparam int AW = 64;

    typedef enum logic [4:0] {
        S_IDLE, S_C1, S_W1, S_MAG, S_C2, S_W2, S_INC_R, S_INC_P,
        S_B1_R, S_B2_R, S_B1_P, S_B2_P, S_E0, S_E1, S_E2, S_E3, S_E4,
        S_MOT, S_OUT
    } state_t;

    state_t state_reg;
    logic [23:0] g_roll_reg, g_pitch_reg, g_rr_reg, g_pr_reg, g_yr_reg, h_reg;
    logic [15:0] bw_reg, base_reg;
    logic signed [23:0] roll_est_reg, pitch_est_reg;
    logic signed [15:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg, gz_reg;
    logic signed [15:0] tr_reg, tp_reg, trr_reg, tpr_reg, tyr_reg;
    logic [15:0] thr_reg;
    logic signed [23:0] roll_meas_reg, pitch_meas_reg;
    logic signed [25:0] pred_r_reg, pred_p_reg;
    logic signed [27:0] mag_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [AW-1:0] sa_reg, sp_reg, sr_reg, sq_reg, sy_reg;
    logic [2:0] mi_reg;
    logic [15:0] m_reg [4];
    logic ov_reg;
    logic [15:0] o_m_reg [4];
    logic signed [15:0] o_re_reg, o_pe_reg;

    afl_pkg::cordic_req_t creq;
    afl_pkg::cordic_rsp_t crsp;

    afl_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .req(creq), .rsp(crsp)
    );

    // Shared multiplier: one signed 34 x 25 product per cycle.
    logic signed [33:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [AW-1:0] prod;
    assign prod = AW'(mul_a) * AW'(mul_b);

    function automatic logic signed [23:0] to_units(input logic signed [25:0] z);
        logic signed [AW-1:0] u;
        u = (AW'(z) + (AW'(1) <<< (USH - 1))) >>> USH;
        if (u < -AW'(LIM))
            return -24'(LIM);
        if (u > AW'(LIM))
            return 24'(LIM);
        return 24'(u);
    endfunction

    function automatic logic signed [23:0] clamp_lim(input logic signed [AW-1:0] v);
        if (v < -AW'(LIM))
            return -24'(LIM);
        if (v > AW'(LIM))
            return 24'(LIM);
        return 24'(v);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
        if (v < -24'sd32768)
            return -16'sd32768;
        if (v > 24'sd32767)
            return 16'sd32767;
        return 16'(v);
    endfunction

    logic signed [AW-1:0] msum;
    logic signed [AW-1:0] mval;
    always_comb
    begin
        case (mi_reg)
            3'd0: msum = -sa_reg - sp_reg - sr_reg - sq_reg - sy_reg;
            3'd1: msum = -sa_reg + sp_reg - sr_reg + sq_reg + sy_reg;
            3'd2: msum = sa_reg + sp_reg + sr_reg + sq_reg - sy_reg;
            default: msum = sa_reg - sp_reg + sr_reg - sq_reg + sy_reg;
        endcase
        mval = ((msum + (AW'(1) <<< (MSH - 1))) >>> MSH) + $signed(AW'(thr_reg))
            + $signed(AW'(base_reg));
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MAG: begin mul_a = 34'(mag_reg); mul_b = 25'(afl_pkg::INV_GAIN_Q16); end
            S_INC_R: begin mul_a = 34'(gx_reg); mul_b = 25'(h_reg); end
            S_INC_P: begin mul_a = 34'(gy_reg); mul_b = 25'(h_reg); end
            S_B1_R: begin mul_a = 34'(roll_meas_reg); mul_b = 25'(17'h10000 - 17'(bw_reg)); end
            S_B2_R: begin mul_a = 34'(pred_r_reg); mul_b = 25'(bw_reg); end
            S_B1_P: begin mul_a = 34'(pitch_meas_reg); mul_b = 25'(17'h10000 - 17'(bw_reg)); end
            S_B2_P: begin mul_a = 34'(pred_p_reg); mul_b = 25'(bw_reg); end
            S_E0: begin mul_a = 34'(tr_reg) - 34'(roll_est_reg); mul_b = 25'(g_roll_reg); end
            S_E1: begin mul_a = 34'(tp_reg) - 34'(pitch_est_reg); mul_b = 25'(g_pitch_reg); end
            S_E2: begin mul_a = 34'(trr_reg) - 34'(gx_reg); mul_b = 25'(g_rr_reg); end
            S_E3: begin mul_a = 34'(tpr_reg) - 34'(gy_reg); mul_b = 25'(g_pr_reg); end
            S_E4: begin mul_a = 34'(tyr_reg) - 34'(gz_reg); mul_b = 25'(g_yr_reg); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb
    begin
        creq.start = 1'b0;
        creq.x = '0;
        creq.y = '0;
        case (state_reg)
            S_C1:
            begin
                creq.start = 1'b1;
                creq.x = 26'(az_reg) <<< 8;
                creq.y = 26'(ay_reg) <<< 8;
            end
            S_C2:
            begin
                creq.start = 1'b1;
                creq.x = 26'(mag_reg);
                creq.y = -(26'(ax_reg) <<< 8);
            end
            default: creq.start = 1'b0;
        endcase
    end

    logic in_fire, out_fire, cfg_fire;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_fire = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;
    assign cfg_ch.ready = 1'b1;
    assign cfg_fire = cfg_ch.valid && cfg_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_roll_reg <= afl_pkg::RST_GAIN_ROLL;
            g_pitch_reg <= afl_pkg::RST_GAIN_PITCH;
            g_rr_reg <= afl_pkg::RST_GAIN_ROLL_RATE;
            g_pr_reg <= afl_pkg::RST_GAIN_PITCH_RATE;
            g_yr_reg <= afl_pkg::RST_GAIN_YAW_RATE;
            bw_reg <= afl_pkg::RST_BLEND_WEIGHT;
            h_reg <= afl_pkg::RST_TIME_STEP;
            base_reg <= afl_pkg::RST_BASE_OFFSET;
        end
        else if (cfg_fire)
        begin
            case (cfg_ch.index)
                afl_pkg::REG_GAIN_ROLL: g_roll_reg <= cfg_ch.data;
                afl_pkg::REG_GAIN_PITCH: g_pitch_reg <= cfg_ch.data;
                afl_pkg::REG_GAIN_ROLL_RATE: g_rr_reg <= cfg_ch.data;
                afl_pkg::REG_GAIN_PITCH_RATE: g_pr_reg <= cfg_ch.data;
                afl_pkg::REG_GAIN_YAW_RATE: g_yr_reg <= cfg_ch.data;
                afl_pkg::REG_BLEND_WEIGHT: bw_reg <= cfg_ch.data[15:0];
                afl_pkg::REG_TIME_STEP: h_reg <= cfg_ch.data;
                afl_pkg::REG_BASE_OFFSET: base_reg <= cfg_ch.data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            roll_est_reg <= '0;
            pitch_est_reg <= '0;
            ov_reg <= 1'b0;
            mi_reg <= '0;
        end
        else
        begin
            if (out_fire && state_reg != S_OUT)
                ov_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (in_fire)
                    begin
                        ax_reg <= in_ch.accel_x;
                        ay_reg <= in_ch.accel_y;
                        az_reg <= in_ch.accel_z;
                        gx_reg <= in_ch.gyro_x;
                        gy_reg <= in_ch.gyro_y;
                        gz_reg <= in_ch.gyro_z;
                        tr_reg <= in_ch.target_roll;
                        tp_reg <= in_ch.target_pitch;
                        trr_reg <= in_ch.target_roll_rate;
                        tpr_reg <= in_ch.target_pitch_rate;
                        tyr_reg <= in_ch.target_yaw_rate;
                        thr_reg <= in_ch.thrust_level;
                        state_reg <= S_C1;
                    end
                S_C1: state_reg <= S_W1;
                S_W1:
                    if (crsp.done)
                    begin
                        roll_meas_reg <= to_units(crsp.z);
                        mag_reg <= crsp.mag;
                        state_reg <= S_MAG;
                    end
                S_MAG:
                begin
                    mag_reg <= 28'((prod + AW'(32768)) >>> 16);
                    state_reg <= S_C2;
                end
                S_C2: state_reg <= S_W2;
                S_W2:
                    if (crsp.done)
                    begin
                        pitch_meas_reg <= to_units(crsp.z);
                        state_reg <= S_INC_R;
                    end
                S_INC_R:
                begin
                    pred_r_reg <= 26'(roll_est_reg)
                        + 26'((prod + (AW'(1) <<< (GSH - 1))) >>> GSH);
                    state_reg <= S_INC_P;
                end
                S_INC_P:
                begin
                    pred_p_reg <= 26'(pitch_est_reg)
                        + 26'((prod + (AW'(1) <<< (GSH - 1))) >>> GSH);
                    state_reg <= S_B1_R;
                end
                S_B1_R:
                begin
                    acc_reg <= prod;
                    state_reg <= S_B2_R;
                end
                S_B2_R:
                begin
                    roll_est_reg <= clamp_lim((acc_reg + prod + AW'(32768)) >>> 16);
                    state_reg <= S_B1_P;
                end
                S_B1_P:
                begin
                    acc_reg <= prod;
                    state_reg <= S_B2_P;
                end
                S_B2_P:
                begin
                    pitch_est_reg <= clamp_lim((acc_reg + prod + AW'(32768)) >>> 16);
                    state_reg <= S_E0;
                end
                S_E0: begin sa_reg <= prod <<< 4; state_reg <= S_E1; end
                S_E1: begin sp_reg <= prod <<< 4; state_reg <= S_E2; end
                S_E2: begin sr_reg <= prod <<< ANGLE_FRAC_BITS; state_reg <= S_E3; end
                S_E3: begin sq_reg <= prod <<< ANGLE_FRAC_BITS; state_reg <= S_E4; end
                S_E4:
                begin
                    sy_reg <= prod <<< ANGLE_FRAC_BITS;
                    mi_reg <= '0;
                    state_reg <= S_MOT;
                end
                S_MOT:
                begin
                    if (mval < 0)
                        m_reg[mi_reg[1:0]] <= 16'd0;
                    else if (mval > AW'(65535))
                        m_reg[mi_reg[1:0]] <= 16'hFFFF;
                    else
                        m_reg[mi_reg[1:0]] <= 16'(mval);
                    mi_reg <= mi_reg + 3'd1;
                    if (mi_reg == 3'd3)
                        state_reg <= S_OUT;
                end
                S_OUT:
                    if (!ov_reg || out_fire)
                    begin
                        ov_reg <= 1'b1;
                        o_m_reg <= m_reg;
                        o_re_reg <= sat16(roll_est_reg);
                        o_pe_reg <= sat16(pitch_est_reg);
                        state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid = ov_reg;
    assign out_ch.motor_one = o_m_reg[0];
    assign out_ch.motor_two = o_m_reg[1];
    assign out_ch.motor_three = o_m_reg[2];
    assign out_ch.motor_four = o_m_reg[3];
    assign out_ch.roll_estimate_out = o_re_reg;
    assign out_ch.pitch_estimate_out = o_pe_reg;

    a_est_range: assert property (@(posedge clk) disable iff (!rst_n)
        roll_est_reg <= 24'(LIM) && roll_est_reg >= -24'(LIM)) else $error("roll range");
    a_pest_range: assert property (@(posedge clk) disable iff (!rst_n)
        pitch_est_reg <= 24'(LIM) && pitch_est_reg >= -24'(LIM)) else $error("pitch range");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !out_ch.ready |=> ov_reg && $stable(o_re_reg)) else $error("result lost");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == S_C1) else $error("bad start");
endmodule
